FILE: hw/rtl/lzc_pkg.sv
// ----------------------------------------------------------------------------
// lzc_pkg
// Types, constants and helpers shared by the zero-crossing edge core and its
// channel interfaces.
// ----------------------------------------------------------------------------
package lzc_pkg;

   localparam int PIX_W      = 8;
   localparam int LAP_W      = 12;
   localparam int DIM_W      = 11;
   localparam int THR_W      = 12;
   localparam int POS_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // result buffer
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

   // -8 x centre is a left shift by three
   localparam int CENTRE_SHIFT = 3;

   localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;
   localparam logic [THR_W-1:0] THRESH_RST = 12'd0;
   localparam logic [DIM_W-1:0] DIM_MIN    = 11'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_WIDTH  = 2'd0,
      CFG_HEIGHT = 2'd1,
      CFG_THRESH = 2'd2
   } cfg_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             drain;
   } req_payload_type;

   typedef struct packed {
      logic             edge_res;
      logic [POS_W-1:0] out_row;
      logic [POS_W-1:0] out_col;
      logic             frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] value;
   } csr_payload_type;

   // one column of a 3x3 window, top row oldest
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } pix_col_type;

   typedef struct packed {
      logic [LAP_W-1:0] top;
      logic [LAP_W-1:0] mid;
      logic [LAP_W-1:0] bot;
   } lap_col_type;

   // opposite strict signs and |a-b| at least the threshold
   function automatic logic pair_cross(input logic signed [LAP_W-1:0] a,
                                       input logic signed [LAP_W-1:0] b,
                                       input logic [THR_W-1:0]        thr);
      logic signed [LAP_W:0] diff;
      logic        [LAP_W:0] mag;
      logic                  opp;
      diff = (LAP_W+1)'(a) - (LAP_W+1)'(b);
      mag  = diff[LAP_W] ? (LAP_W+1)'(-diff) : (LAP_W+1)'(diff);
      opp  = (a < 0 && b > 0) || (a > 0 && b < 0);
      return opp && (mag >= (LAP_W+1)'(thr));
   endfunction

endpackage

FILE: hw/rtl/lzc_if.sv
// ----------------------------------------------------------------------------
// lzc_if
// Valid/ready channels of the zero-crossing edge core: pixel input, decision
// output and register write port.
// ----------------------------------------------------------------------------
interface lzc_req_if;
   import lzc_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lzc_rsp_if;
   import lzc_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lzc_csr_if;
   import lzc_pkg::*;

   logic            valid;
   logic            ready;
   csr_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/laplacian_zero_crossing_edge_core.sv
// ----------------------------------------------------------------------------
// laplacian_zero_crossing_edge_core
// 3x3 Laplacian (centre -8) with mirrored borders, then a zero-crossing test
// over four opposite neighbour pairs of the Laplacian.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  : one item per pixel in raster order; drain=1 items flush the frame
//             (2*W+2 of them after the last pixel). A drain while pixels are
//             still expected is taken and ignored.
//   rsp_if  : one decision per pixel in raster order, with its row and column;
//             frame_last marks the final decision of a frame. Outer ring is 0.
//   csr_if  : register writes (0 width, 1 height, 2 threshold), always ready.
//             Width and height are sampled by the first item of a frame.
// Throughput: one item per clock. Each item does one read and one write in the
//   pixel line memory and in the Laplacian line memory, on separate cycles.
// Decisions: the decision for pixel n is produced by the item at stream position
//   n+2*W+2 and passes through registers s1 to s4 and the result buffer to rsp_if.
// Stall: decisions queue in an 8-entry buffer; req_if.ready drops only when
//   8 decisions are queued or in flight, so a stalled receiver holds the input.
// Reset: frame position returns to the start, registers to 640 x 480 and
//   threshold 0. Line memories are not cleared; no stale entry is ever used.
// ----------------------------------------------------------------------------
module laplacian_zero_crossing_edge_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic       clock,
   input  logic       reset,
   lzc_req_if.sink    req_if,
   lzc_rsp_if.source  rsp_if,
   lzc_csr_if.sink    csr_if
);
   import lzc_pkg::*;

   localparam int CI_W = $clog2(MAX_WIDTH);
   localparam int WD_W = $clog2(MAX_WIDTH + 1);
   localparam int HT_W = $clog2(MAX_HEIGHT + 1);
   localparam int RI_W = $clog2(MAX_HEIGHT + 3);
   localparam int OR_W = $clog2(MAX_HEIGHT);

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [CI_W-1:0]  col;
      logic             top;     // Laplacian centre on first row
      logic             bot;     // ... on last row
      logic             left;    // ... on first column
      logic             right;   // ... on last column
      logic             res;     // item emits a decision
      logic             inner;   // decided pixel off the outer ring
      logic             last;
      logic [POS_W-1:0] row_o;
      logic [POS_W-1:0] col_o;
   } stage_type;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   logic [DIM_W-1:0] cfg_width_ff;
   logic [DIM_W-1:0] cfg_height_ff;
   logic [THR_W-1:0] cfg_thresh_ff;

   logic [WD_W-1:0]  wd_ff;
   logic [HT_W-1:0]  ht_ff;

   logic [RI_W-1:0]  row_ff, row_in;
   logic [CI_W-1:0]  col_ff, col_in;
   logic [OR_W-1:0]  orow_ff, orow_in;
   logic [CI_W-1:0]  ocol_ff, ocol_in;

   function automatic logic [WD_W-1:0] clamp_width(input logic [DIM_W-1:0] v);
      if (v < DIM_MIN) return WD_W'(DIM_MIN);
      if (32'(v) > MAX_WIDTH) return WD_W'(MAX_WIDTH);
      return WD_W'(v);
   endfunction

   function automatic logic [HT_W-1:0] clamp_height(input logic [DIM_W-1:0] v);
      if (v < DIM_MIN) return HT_W'(DIM_MIN);
      if (32'(v) > MAX_HEIGHT) return HT_W'(MAX_HEIGHT);
      return HT_W'(v);
   endfunction

   // ------------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------------
   logic csr_wr;

   assign csr_if.ready = 1'b1;
   assign csr_wr       = csr_if.valid && csr_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= WIDTH_RST;
         cfg_height_ff <= HEIGHT_RST;
         cfg_thresh_ff <= THRESH_RST;
      end else if (csr_wr) begin
         unique case (csr_if.data.index)
            CFG_WIDTH:  cfg_width_ff  <= csr_if.data.value[DIM_W-1:0];
            CFG_HEIGHT: cfg_height_ff <= csr_if.data.value[DIM_W-1:0];
            CFG_THRESH: cfg_thresh_ff <= csr_if.data.value[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Input stage: stream position, frame geometry, per-item flags
   // ------------------------------------------------------------------------
   logic [FIFO_CNT_W-1:0] resv_ff, resv_in;
   logic                  accept, adv, in_flush, frame_start;
   logic                  item_res, item_last, row_wrap, ocol_wrap;
   stage_type             s1_in;

   assign req_if.ready = resv_ff < FIFO_CNT_W'(FIFO_DEPTH);
   assign accept       = req_if.valid && req_if.ready;
   assign frame_start  = (row_ff == '0) && (col_ff == '0);
   assign in_flush     = row_ff >= RI_W'(ht_ff);
   // drains are dropped until the last pixel of the frame is in
   assign adv          = accept && (in_flush || !req_if.data.drain);

   assign item_res  = (row_ff >= RI_W'(3)) || ((row_ff == RI_W'(2)) && (col_ff >= CI_W'(2)));
   assign item_last = (HT_W'(orow_ff) == ht_ff - HT_W'(1)) &&
                      (WD_W'(ocol_ff) == wd_ff - WD_W'(1));
   assign row_wrap  = WD_W'(col_ff) == wd_ff - WD_W'(1);
   assign ocol_wrap = WD_W'(ocol_ff) == wd_ff - WD_W'(1);

   always_comb begin
      s1_in.pixel = req_if.data.pixel;
      s1_in.col   = col_ff;
      // Laplacian centre sits W+1 positions behind the incoming pixel
      s1_in.top   = ((col_ff != '0) && (row_ff == RI_W'(1))) ||
                    ((col_ff == '0) && (row_ff == RI_W'(2)));
      s1_in.bot   = ((col_ff != '0) && (row_ff == RI_W'(ht_ff))) ||
                    ((col_ff == '0) && (row_ff == RI_W'(ht_ff) + RI_W'(1)));
      s1_in.left  = col_ff == CI_W'(1);
      s1_in.right = col_ff == '0;
      s1_in.res   = item_res;
      s1_in.inner = (orow_ff != '0) && (HT_W'(orow_ff) <= ht_ff - HT_W'(2)) &&
                    (ocol_ff != '0) && (WD_W'(ocol_ff) <= wd_ff - WD_W'(2));
      s1_in.last  = item_last;
      s1_in.row_o = POS_W'(orow_ff);
      s1_in.col_o = POS_W'(ocol_ff);
   end

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      orow_in = orow_ff;
      ocol_in = ocol_ff;
      if (adv) begin
         if (item_res && item_last) begin
            row_in  = '0;
            col_in  = '0;
            orow_in = '0;
            ocol_in = '0;
         end else begin
            if (row_wrap) begin
               col_in = '0;
               row_in = row_ff + RI_W'(1);
            end else begin
               col_in = col_ff + CI_W'(1);
            end
            if (item_res) begin
               if (ocol_wrap) begin
                  ocol_in = '0;
                  orow_in = orow_ff + OR_W'(1);
               end else begin
                  ocol_in = ocol_ff + CI_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         orow_ff <= '0;
         ocol_ff <= '0;
         wd_ff   <= WD_W'(DIM_MIN);
         ht_ff   <= HT_W'(DIM_MIN);
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         orow_ff <= orow_in;
         ocol_ff <= ocol_in;
         if (accept && frame_start) begin
            wd_ff <= clamp_width(cfg_width_ff);
            ht_ff <= clamp_height(cfg_height_ff);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Pixel line memory and pixel window
   // Entry per column: {two rows back, one row back}. Read when the item is
   // taken, written back in the cycle after. The same column comes round again
   // only W >= 3 items later, so read and write-back never meet.
   // ------------------------------------------------------------------------
   logic [2*PIX_W-1:0] pix_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] pix_rd_ff;
   stage_type          s1_ff, s2_ff, s3_ff, s4_ff;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   pix_col_type        pcol_ff [3];

   always_ff @(posedge clock) begin
      if (adv) pix_rd_ff <= pix_mem[col_ff];
      if (v1_ff) pix_mem[s1_ff.col] <= {pix_rd_ff[PIX_W-1:0], s1_ff.pixel};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= adv;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) s1_ff <= s1_in;
      if (v1_ff) begin
         s2_ff      <= s1_ff;
         pcol_ff[0] <= pcol_ff[1];
         pcol_ff[1] <= pcol_ff[2];
         pcol_ff[2] <= '{top: pix_rd_ff[2*PIX_W-1:PIX_W],
                         mid: pix_rd_ff[PIX_W-1:0],
                         bot: s1_ff.pixel};
      end
   end

   // ------------------------------------------------------------------------
   // Laplacian with mirrored borders (index -1 reads 1, index n reads n-2)
   // ------------------------------------------------------------------------
   logic [PIX_W-1:0]        tsel [3];
   logic [PIX_W-1:0]        bsel [3];
   logic [PIX_W-1:0]        t_l, t_r, m_l, m_r, b_l, b_r;
   logic [DIM_W-1:0]        nbr_sum;
   logic [LAP_W-1:0]        lap_val;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         tsel[k] = s2_ff.top ? pcol_ff[k].bot : pcol_ff[k].top;
         bsel[k] = s2_ff.bot ? pcol_ff[k].top : pcol_ff[k].bot;
      end
      t_l = s2_ff.left  ? tsel[2] : tsel[0];
      t_r = s2_ff.right ? tsel[0] : tsel[2];
      m_l = s2_ff.left  ? pcol_ff[2].mid : pcol_ff[0].mid;
      m_r = s2_ff.right ? pcol_ff[0].mid : pcol_ff[2].mid;
      b_l = s2_ff.left  ? bsel[2] : bsel[0];
      b_r = s2_ff.right ? bsel[0] : bsel[2];
      nbr_sum = (DIM_W'(t_l) + DIM_W'(tsel[1])) + (DIM_W'(t_r) + DIM_W'(m_l)) +
                (DIM_W'(m_r) + DIM_W'(b_l)) + (DIM_W'(bsel[1]) + DIM_W'(b_r));
      lap_val = LAP_W'(nbr_sum) - (LAP_W'(pcol_ff[1].mid) << CENTRE_SHIFT);
   end

   // ------------------------------------------------------------------------
   // Laplacian line memory and window, same scheme as the pixel side
   // ------------------------------------------------------------------------
   logic [2*LAP_W-1:0] lap_mem [MAX_WIDTH];
   logic [2*LAP_W-1:0] lap_rd_ff;
   logic [LAP_W-1:0]   lap_ff;
   lap_col_type        lcol_ff [3];

   always_ff @(posedge clock) begin
      if (v2_ff) lap_rd_ff <= lap_mem[s2_ff.col];
      if (v3_ff) lap_mem[s3_ff.col] <= {lap_rd_ff[LAP_W-1:0], lap_ff};
   end

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         s3_ff  <= s2_ff;
         lap_ff <= lap_val;
      end
      if (v3_ff) begin
         s4_ff      <= s3_ff;
         lcol_ff[0] <= lcol_ff[1];
         lcol_ff[1] <= lcol_ff[2];
         lcol_ff[2] <= '{top: lap_rd_ff[2*LAP_W-1:LAP_W],
                         mid: lap_rd_ff[LAP_W-1:0],
                         bot: lap_ff};
      end
   end

   // ------------------------------------------------------------------------
   // Zero-crossing decision: N/S, W/E, NE/SW, NW/SE
   // ------------------------------------------------------------------------
   logic edge_dec;

   always_comb begin
      edge_dec = s4_ff.inner &&
         (pair_cross(lcol_ff[1].top, lcol_ff[1].bot, cfg_thresh_ff) ||
          pair_cross(lcol_ff[0].mid, lcol_ff[2].mid, cfg_thresh_ff) ||
          pair_cross(lcol_ff[2].top, lcol_ff[0].bot, cfg_thresh_ff) ||
          pair_cross(lcol_ff[0].top, lcol_ff[2].bot, cfg_thresh_ff));
   end

   // ------------------------------------------------------------------------
   // Result buffer; entries are reserved when the item is taken
   // ------------------------------------------------------------------------
   rsp_payload_type       rsp_buf_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] fifo_cnt_ff;
   logic                  push, pop;

   assign push          = v4_ff && s4_ff.res;
   assign pop           = rsp_if.valid && rsp_if.ready;
   assign rsp_if.valid  = fifo_cnt_ff != '0;
   assign rsp_if.data   = rsp_buf_ff[rd_ptr_ff];

   // a dropped drain makes no decision and so reserves nothing
   assign resv_in = resv_ff + FIFO_CNT_W'(adv && item_res) - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_buf_ff[wr_ptr_ff] <= '{edge_res:   edge_dec,
                                    out_row:    s4_ff.row_o,
                                    out_col:    s4_ff.col_o,
                                    frame_last: s4_ff.last};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         resv_ff     <= '0;
      end else begin
         resv_ff <= resv_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         fifo_cnt_ff <= fifo_cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      end
   end

`ifndef SYNTHESIS
   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (fifo_cnt_ff == FIFO_CNT_W'(FIFO_DEPTH))))
      else $error("result buffer overflow");

   a_resv_covers_fifo: assert property (@(posedge clock) disable iff (reset)
      resv_ff >= fifo_cnt_ff)
      else $error("reservation count below buffer fill");

   a_pix_mem_no_clash: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && adv) |-> (s1_ff.col != col_ff))
      else $error("pixel line read and write-back on the same column");

   a_lap_mem_no_clash: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && v2_ff) |-> (s3_ff.col != s2_ff.col))
      else $error("Laplacian line read and write-back on the same column");

   a_last_on_ring: assert property (@(posedge clock) disable iff (reset)
      push |=> !(s4_ff.last && rsp_buf_ff[$past(wr_ptr_ff)].edge_res))
      else $error("edge reported on the last pixel of a frame");
`endif

endmodule
